### design/kth_largest_select_core_macros.svh
// ----------------------------------------------------------------------------
// kth_largest_select_core_macros
// assertion macros for the k-th largest selection core
// ----------------------------------------------------------------------------
`ifndef KTH_LARGEST_SELECT_CORE_MACROS_SVH
`define KTH_LARGEST_SELECT_CORE_MACROS_SVH

`ifndef SYNTHESIS

`define KLS_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`define KLS_ASSERT_NEVER(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`else

`define KLS_ASSERT(label, clk, rst, prop, msg)

`define KLS_ASSERT_NEVER(label, clk, rst, expr, msg)

`endif

`endif

### design/kls_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kls_pkg
// shared types and constants of the k-th largest selection core
// ----------------------------------------------------------------------------
package kls_pkg;

   localparam int DATA_W           = 32;
   localparam int RANK_W           = 7;
   localparam int MAX_RANK_DEFAULT = 64;

   // what one cell hands to its right-hand neighbour
   typedef struct packed {
      logic                     keep;
      logic signed [DATA_W-1:0] value;
   } kls_link_type;

endpackage

### design/kls_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kls_cell
// one slot of the sorted insertion row
// ----------------------------------------------------------------------------
module kls_cell
   import kls_pkg::*;
#(
   parameter int MAX_RANK = MAX_RANK_DEFAULT,
   parameter int INDEX    = 0
) (
   input  logic                              clock,
   input  logic                              load,
   input  logic signed [DATA_W-1:0]          x,
   input  logic [$clog2(MAX_RANK+1)-1:0]     cnt,
   input  kls_link_type                      left,
   output kls_link_type                      right
);

   localparam int CW = $clog2(MAX_RANK + 1);

   logic                     occupied;
   logic                     gt;
   logic signed [DATA_W-1:0] value_ff;
   logic signed [DATA_W-1:0] value_in;

   assign occupied = (CW'(INDEX) < cnt);
   // ties keep the older value in front
   assign gt       = occupied && (value_ff >= x);

   always_comb begin
      value_in = value_ff;
      if (!left.keep) begin
         value_in = left.value;
      end else if (!gt) begin
         value_in = x;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         value_ff <= value_in;
      end
   end

   assign right.keep  = gt;
   assign right.value = value_ff;

endmodule

### design/kth_largest_select_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kth_largest_select_core
// streaming k-th largest selection over sets of signed values
// ----------------------------------------------------------------------------
// Takes one signed 32-bit value per clock and keeps the k largest of the
// current set, sorted descending, in a row of MAX_RANK insertion cells; every
// cell compares the new value against its own in the same cycle and either
// holds, takes the new value or takes its left neighbour's value. A value
// with the last flag closes the set and sets a pending flag; from there the
// k-th cell is read into the output register once that register is free or
// its result is being taken, and the count restarts for the next set.
// Throughput is one value per cycle; the input stalls only while a finished
// result waits behind an output register that has not been taken.
// rsp_valid_res is low, with rsp_kth_largest zero, when the set held fewer
// than k values. rank_k of zero acts as one and values above MAX_RANK
// saturate.
// ----------------------------------------------------------------------------
`include "kth_largest_select_core_macros.svh"

module kth_largest_select_core
   import kls_pkg::*;
#(
   parameter int MAX_RANK = MAX_RANK_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic signed [DATA_W-1:0] req_value,
   input  logic                     req_last,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic signed [DATA_W-1:0] rsp_kth_largest,
   output logic                     rsp_valid_res,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [RANK_W-1:0]        csr_rank_k
);

   localparam int CW = $clog2(MAX_RANK + 1);
   localparam int IW = (MAX_RANK > 1) ? $clog2(MAX_RANK) : 1;
   localparam int EW = (CW > RANK_W) ? CW : RANK_W;

   logic [RANK_W-1:0]        rank_k_ff;
   logic [CW-1:0]            count_ff;
   logic [CW-1:0]            count_in;
   logic                     pend_ff;
   logic                     pend_in;
   logic                     pend_res_ff;
   logic                     pend_res_in;
   logic                     rsp_valid_ff;
   logic                     rsp_valid_in;
   logic signed [DATA_W-1:0] rsp_kth_ff;
   logic signed [DATA_W-1:0] rsp_kth_in;
   logic                     rsp_res_ff;
   logic                     rsp_res_in;

   logic [EW-1:0]            rank_ext;
   logic [EW-1:0]            k_ext;
   logic [CW-1:0]            k;
   logic [CW-1:0]            k_m1;
   logic [CW-1:0]            cnt_eff;
   logic [CW-1:0]            cnt_next;
   logic                     req_acc;
   logic                     pend_move;

   kls_link_type             link [MAX_RANK+1];
   logic signed [DATA_W-1:0] cell_value [MAX_RANK];

   // effective rank
   assign rank_ext = EW'(rank_k_ff);
   always_comb begin
      if (rank_ext == '0) begin
         k_ext = EW'(1);
      end else if (rank_ext > EW'(MAX_RANK)) begin
         k_ext = EW'(MAX_RANK);
      end else begin
         k_ext = rank_ext;
      end
   end
   assign k        = k_ext[CW-1:0];
   assign k_m1     = k - CW'(1);
   assign cnt_eff  = (count_ff > k) ? k : count_ff;
   assign cnt_next = (cnt_eff < k) ? cnt_eff + CW'(1) : cnt_eff;

   assign pend_move = pend_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !pend_ff || pend_move;
   assign req_acc   = req_valid && req_ready;
   assign csr_ready = 1'b1;

   // insertion row
   assign link[0].keep  = 1'b1;
   assign link[0].value = '0;

   for (genvar i = 0; i < MAX_RANK; i++) begin : g_cell
      kls_cell #(
         .MAX_RANK (MAX_RANK),
         .INDEX    (i)
      ) u_cell (
         .clock (clock),
         .load  (req_acc),
         .x     (req_value),
         .cnt   (cnt_eff),
         .left  (link[i]),
         .right (link[i+1])
      );
      assign cell_value[i] = link[i+1].value;
   end

   always_comb begin
      count_in     = count_ff;
      pend_in      = pend_ff;
      pend_res_in  = pend_res_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_kth_in   = rsp_kth_ff;
      rsp_res_in   = rsp_res_ff;
      if (pend_move) begin
         pend_in      = 1'b0;
         rsp_valid_in = 1'b1;
         rsp_res_in   = pend_res_ff;
         rsp_kth_in   = pend_res_ff ? cell_value[k_m1[IW-1:0]] : '0;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (req_acc) begin
         if (req_last) begin
            count_in    = '0;
            pend_in     = 1'b1;
            pend_res_in = (cnt_next == k);
         end else begin
            count_in = cnt_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rank_k_ff    <= RANK_W'(1);
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            rank_k_ff <= csr_rank_k;
         end
         count_ff     <= count_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_res_ff <= pend_res_in;
      rsp_kth_ff  <= rsp_kth_in;
      rsp_res_ff  <= rsp_res_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_kth_largest = rsp_kth_ff;
   assign rsp_valid_res   = rsp_res_ff;

   // checks
   `KLS_ASSERT(a_count_clears, clock, reset, (req_acc && req_last) |=> (count_ff == '0), "count not cleared after closing transaction")
   `KLS_ASSERT(a_short_set_zero, clock, reset, (rsp_valid && !rsp_valid_res) |-> (rsp_kth_largest == '0), "short set result not zero")
   `KLS_ASSERT_NEVER(a_count_range, clock, reset, (count_ff > CW'(MAX_RANK)), "kept count beyond row length")

endmodule
